// ===== sv/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  // Built depth and field widths
  localparam int DEPTH_DEF  = 16;
  localparam int VALUE_W    = 32;
  localparam int PRIO_W     = 16;
  localparam int CAP_W      = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_CAPACITY = REG_IDX_W'(0);

  // Operation codes
  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NOP  = 2'd3
  } opcode_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Per-cycle command broadcast along the row
  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2
  } cell_cmd_t;

  // One stored entry
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
  } entry_t;

  // Control carried from the top level to every cell
  typedef struct packed {
    cell_cmd_t cmd;
    entry_t    new_ent;
  } cell_ctrl_t;

endpackage

// ===== sv/sorted_priority_queue.sv =====
// Sorted priority queue: a row of shifting cells with APB-style configuration.
// The result of an accepted operation is written to the output register in the cycle after it is accepted.
// Throughput: one operation per cycle while the result channel is not stalled; each cell compares and shifts.
// The output register lets a new operation enter while the last result is still taken.
// Reset (synchronous, rst_n low): fill count zero, capacity limit 16, no result pending.
// Cell contents are not reset; only slots below the fill count are ever read.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_opcode,
  input  logic signed [VALUE_W-1:0] in_item_value,
  input  logic signed [PRIO_W-1:0]  in_item_priority,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_status,
  output logic signed [VALUE_W-1:0] out_head_value,
  output logic signed [PRIO_W-1:0]  out_head_priority,
  output logic [CNT_W-1:0]        out_fill_count,
  // configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CFG_ADDR_W-1:0]   paddr,
  input  logic [CFG_DATA_W-1:0]   pwdata,
  output logic [CFG_DATA_W-1:0]   prdata,
  output logic                    pready
);

  localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          status_r, status_nxt;
  entry_t           head_r, head_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;

  logic             in_fire;
  logic             cfg_wr;
  opcode_t          op;
  logic [LIM_W-1:0] lim;
  logic             full;
  logic             empty;
  cell_ctrl_t       ctrl;
  entry_t           ents [DEPTH];
  logic [DEPTH-1:0] keeps;

  // Configuration access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cap_nxt = cap_r;
    if (cfg_wr && (paddr[CFG_ADDR_W-1:2] == REG_CAPACITY)) begin
      cap_nxt = pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[CFG_ADDR_W-1:2] == REG_CAPACITY) begin
      prdata = CFG_DATA_W'(cap_r);
    end
  end

  // Limit in force and occupancy checks
  assign lim   = (LIM_W'(cap_r) > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : LIM_W'(cap_r);
  assign full  = LIM_W'(cnt_r) >= lim;
  assign empty = (cnt_r == '0);

  // Handshake
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign op       = opcode_t'(in_opcode);

  // Operation decode, fill count and result
  always_comb begin
    ctrl.cmd         = CMD_HOLD;
    ctrl.new_ent.value = in_item_value;
    ctrl.new_ent.prio  = in_item_priority;
    cnt_nxt          = cnt_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    status_nxt       = status_r;
    head_nxt         = head_r;
    fill_nxt         = fill_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      status_nxt    = ST_DONE;
      head_nxt      = '0;
      case (op)
        OP_ENQ: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ctrl.cmd = CMD_INSERT;
            cnt_nxt  = cnt_r + CNT_W'(1);
          end
        end
        OP_DEQ: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            ctrl.cmd = CMD_REMOVE;
            head_nxt = ents[0];
            cnt_nxt  = cnt_r - CNT_W'(1);
          end
        end
        OP_PEEK: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            head_nxt = ents[0];
          end
        end
        default: status_nxt = ST_DONE;
      endcase
      fill_nxt = cnt_nxt;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    head_r   <= head_nxt;
    fill_r   <= fill_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_head_value    = head_r.value;
  assign out_head_priority = head_r.prio;
  assign out_fill_count    = fill_r;

  // Row of cells, head at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;
    logic   keep_left;
    logic   occ;

    assign occ = (CNT_W'(i) < cnt_r);

    if (i == 0) begin : g_head
      assign left_ent  = ctrl.new_ent;
      assign keep_left = 1'b1;
    end else begin : g_body
      assign left_ent  = ents[i-1];
      assign keep_left = keeps[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_ent = ents[i];
    end else begin : g_inner
      assign right_ent = ents[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (occ),
      .keep_left (keep_left),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .ent       (ents[i]),
      .keep      (keeps[i])
    );
  end

`ifndef SYNTHESIS
  // Fill never passes the built depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    LIM_W'(cnt_r) <= LIM_W'(DEPTH))
    else $error("fill count beyond depth");

  // A dequeue on a non-empty queue drops the fill by one
  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (op == OP_DEQ) && !empty) |=> (cnt_r == $past(cnt_r) - CNT_W'(1)))
    else $error("dequeue did not lower fill");

  // An accepted enqueue with room reports done with the new fill
  a_enq_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (op == OP_ENQ) && !full) |=>
      (out_valid_r && (status_r == ST_DONE) && (fill_r == cnt_r)))
    else $error("enqueue result wrong");

  // Head and second slot stay in priority order
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r >= CNT_W'(2)) |-> (ents[0].prio >= ents[1].prio))
    else $error("row out of order");
`endif

endmodule

// ===== sv/spq_cell.sv =====
// One slot of the sorted row: holds an entry, shifts it or takes the new one.
module spq_cell import spq_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occ,       // slot lies below the fill count
  input  logic       keep_left, // left neighbour stays put on insert
  input  entry_t     left_ent,
  input  entry_t     right_ent,
  output entry_t     ent,
  output logic       keep
);

  entry_t ent_r;
  entry_t ent_nxt;

  // Held entry stays where a new one of lower or equal priority goes behind it
  assign keep = occ && (ent_r.prio >= ctrl.new_ent.prio);
  assign ent  = ent_r;

  // Next contents
  always_comb begin
    ent_nxt = ent_r;
    case (ctrl.cmd)
      CMD_INSERT: begin
        if (!keep) begin
          ent_nxt = keep_left ? ctrl.new_ent : left_ent;
        end
      end
      CMD_REMOVE: ent_nxt = right_ent;
      default:    ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule
